// File: sv/rmq_pkg.sv
// Shared branch codes and element counts for the rotation matrix to quaternion pipeline.
`default_nettype none
package rmq_pkg;
    typedef logic [1:0] t_branch;
    localparam t_branch BR_TRACE = 2'd0;
    localparam t_branch BR_M00   = 2'd1;
    localparam t_branch BR_M11   = 2'd2;
    localparam t_branch BR_M22   = 2'd3;
    localparam int      N_ELEM   = 9;
    localparam int      N_COMP   = 4;
endpackage
`default_nettype wire

// File: sv/rotation_matrix_to_quaternion.sv
// Rotation matrix to unit quaternion (Shepperd's method), fully pipelined.
// Registers in order: radicand load, root stages, numerator stage, divider stages, output register.
// Throughput: one request per cycle unless the output stalls; the square root and the three
// dividers each retire one bit per stage, so every stage takes a new item each cycle.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, active low) clears only the stage valid bits.
`default_nettype none
module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_tvalid,
    output logic      o_s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up, zero padded
    input  wire logic [((rmq_pkg::N_ELEM*DATA_WIDTH+7)/8)*8-1:0] i_s_tdata,
    output logic      o_m_tvalid,
    input  wire logic i_m_tready,
    // qw, qx, qy, qz from bit 0 up, zero padded
    output logic [((rmq_pkg::N_COMP*DATA_WIDTH+7)/8)*8-1:0] o_m_tdata,
    // degenerate
    output logic      o_m_tuser
);
    localparam int W      = DATA_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int OUT_TW = ((rmq_pkg::N_COMP*W+7)/8)*8;
    localparam int RW     = W + 3;
    localparam int NW     = W + 2 + F;
    localparam int SW     = (NW + 1) / 2;
    localparam int DW     = W + 1;
    localparam int AW     = W + 1 + F;
    localparam int NUMW   = AW + 1;
    localparam logic [NUMW-1:0] PMAX = {{(NUMW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [NUMW-1:0] NMAG = PMAX + 1'b1;

    logic w_en;

    // pipeline advances unless a finished result is held
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    // ---------------- front stage: branch, radicand, sum and difference terms
    logic signed [RW-1:0] w_e [0:8];
    logic signed [RW-1:0] w_tr;
    logic signed [RW-1:0] w_rad;
    rmq_pkg::t_branch     w_br;
    logic signed [DW-1:0] w_d [0:2];

    always_comb begin
        for (int e = 0; e < 9; e++) begin
            w_e[e] = RW'($signed(i_s_tdata[e*W +: W]));
        end
        w_tr = w_e[0] + w_e[4] + w_e[8];
        if (w_tr > 0) begin
            w_br = rmq_pkg::BR_TRACE;
        end else if (w_e[0] > w_e[4] && w_e[0] > w_e[8]) begin
            w_br = rmq_pkg::BR_M00;
        end else if (w_e[4] > w_e[8]) begin
            w_br = rmq_pkg::BR_M11;
        end else begin
            w_br = rmq_pkg::BR_M22;
        end
        w_rad = '0;
        w_d[0] = '0;
        w_d[1] = '0;
        w_d[2] = '0;
        unique case (w_br)
            rmq_pkg::BR_TRACE: begin
                w_rad  = RW'(1 << F) + w_tr;
                w_d[0] = DW'(w_e[7] - w_e[5]);
                w_d[1] = DW'(w_e[2] - w_e[6]);
                w_d[2] = DW'(w_e[3] - w_e[1]);
            end
            rmq_pkg::BR_M00: begin
                w_rad  = RW'(1 << F) + w_e[0] - w_e[4] - w_e[8];
                w_d[0] = DW'(w_e[1] + w_e[3]);
                w_d[1] = DW'(w_e[6] + w_e[2]);
                w_d[2] = DW'(w_e[7] - w_e[5]);
            end
            rmq_pkg::BR_M11: begin
                w_rad  = RW'(1 << F) + w_e[4] - w_e[0] - w_e[8];
                w_d[0] = DW'(w_e[1] + w_e[3]);
                w_d[1] = DW'(w_e[5] + w_e[7]);
                w_d[2] = DW'(w_e[2] - w_e[6]);
            end
            default: begin
                w_rad  = RW'(1 << F) + w_e[8] - w_e[0] - w_e[4];
                w_d[0] = DW'(w_e[2] + w_e[6]);
                w_d[1] = DW'(w_e[5] + w_e[7]);
                w_d[2] = DW'(w_e[3] - w_e[1]);
            end
        endcase
    end

    // ---------------- square root pipeline, one root bit per stage
    logic [2*SW-1:0]      r_sq_n    [0:SW];
    logic [SW:0]          r_sq_rem  [0:SW];
    logic [SW-1:0]        r_sq_root [0:SW];
    logic signed [DW-1:0] r_sq_d    [0:SW][0:2];
    rmq_pkg::t_branch     r_sq_br   [0:SW];
    logic                 r_sq_dg   [0:SW];
    logic                 r_sq_vld  [0:SW];

    // load radicand into the first root stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_sq_vld[0] <= i_s_tvalid;
        end
        if (w_en) begin
            r_sq_n[0]    <= (2*SW)'({w_rad[W+1:0], {F{1'b0}}});
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_d[0][0] <= w_d[0];
            r_sq_d[0][1] <= w_d[1];
            r_sq_d[0][2] <= w_d[2];
            r_sq_br[0]   <= w_br;
            r_sq_dg[0]   <= (w_rad <= 0);
        end
    end

    for (genvar k = 0; k < SW; k++) begin : g_sq
        logic [SW+1:0] w_sh;
        logic [SW+1:0] w_trial;
        logic          w_ge;

        assign w_sh    = {r_sq_rem[k][SW-1:0], r_sq_n[k][2*SW-1 -: 2]};
        assign w_trial = {r_sq_root[k], 2'b01};
        assign w_ge    = (w_sh >= w_trial);

        // take one root bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else if (w_en) begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
            if (w_en) begin
                r_sq_n[k+1]    <= {r_sq_n[k][2*SW-3:0], 2'b00};
                r_sq_rem[k+1]  <= w_ge ? (SW+1)'(w_sh - w_trial) : w_sh[SW:0];
                r_sq_root[k+1] <= {r_sq_root[k][SW-2:0], w_ge};
                r_sq_d[k+1]    <= r_sq_d[k];
                r_sq_br[k+1]   <= r_sq_br[k];
                r_sq_dg[k+1]   <= r_sq_dg[k];
            end
        end
    end

    // ---------------- division pipeline, three lanes, one quotient bit per stage
    logic [NUMW-1:0]  r_dv_num [0:NUMW][0:2];
    logic [SW:0]      r_dv_rem [0:NUMW][0:2];
    logic [NUMW-1:0]  r_dv_q   [0:NUMW][0:2];
    logic             r_dv_neg [0:NUMW][0:2];
    logic [SW-1:0]    r_dv_s   [0:NUMW];
    rmq_pkg::t_branch r_dv_br  [0:NUMW];
    logic             r_dv_dg  [0:NUMW];
    logic             r_dv_vld [0:NUMW];

    // form rounded numerators from the root and the magnitudes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_dv_vld[0] <= r_sq_vld[SW];
        end
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r_dv_num[0][j] <= NUMW'({(r_sq_d[SW][j][DW-1] ? DW'(-r_sq_d[SW][j])
                                                          : DW'(r_sq_d[SW][j])),
                                         {F{1'b0}}}) + NUMW'(r_sq_root[SW]);
                r_dv_rem[0][j] <= '0;
                r_dv_q[0][j]   <= '0;
                r_dv_neg[0][j] <= r_sq_d[SW][j][DW-1];
            end
            r_dv_s[0]  <= r_sq_root[SW];
            r_dv_br[0] <= r_sq_br[SW];
            r_dv_dg[0] <= r_sq_dg[SW];
        end
    end

    for (genvar k = 0; k < NUMW; k++) begin : g_dv
        logic [SW+1:0] w_den;
        logic [SW+1:0] w_sh [0:2];
        logic          w_ge [0:2];

        assign w_den = {1'b0, r_dv_s[k], 1'b0};
        always_comb begin
            for (int j = 0; j < 3; j++) begin
                w_sh[j] = {r_dv_rem[k][j], r_dv_num[k][j][NUMW-1]};
                w_ge[j] = (w_sh[j] >= w_den);
            end
        end

        // take one quotient bit in each lane
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k+1] <= 1'b0;
            end else if (w_en) begin
                r_dv_vld[k+1] <= r_dv_vld[k];
            end
            if (w_en) begin
                for (int j = 0; j < 3; j++) begin
                    r_dv_num[k+1][j] <= {r_dv_num[k][j][NUMW-2:0], 1'b0};
                    r_dv_rem[k+1][j] <= w_ge[j] ? (SW+1)'(w_sh[j] - w_den)
                                                : w_sh[j][SW:0];
                    r_dv_q[k+1][j]   <= {r_dv_q[k][j][NUMW-2:0], w_ge[j]};
                    r_dv_neg[k+1][j] <= r_dv_neg[k][j];
                end
                r_dv_s[k+1]  <= r_dv_s[k];
                r_dv_br[k+1] <= r_dv_br[k];
                r_dv_dg[k+1] <= r_dv_dg[k];
            end
        end
    end

    // ---------------- saturation, component placement, output register
    function automatic logic [W-1:0] sat_mag(input logic [NUMW-1:0] q, input logic neg);
        logic [W-1:0] v;
        if (!neg) begin
            v = (q > PMAX) ? {1'b0, {(W-1){1'b1}}} : q[W-1:0];
        end else begin
            v = (q > NMAG) ? {1'b1, {(W-1){1'b0}}} : W'(~q[W-1:0] + 1'b1);
        end
        return v;
    endfunction

    logic [W-1:0]  w_dom;
    logic [W-1:0]  w_off [0:2];
    logic [SW:0]   w_s1;
    logic [W-1:0]  n_q [0:3];
    logic [W-1:0]  r_q [0:3];
    logic          r_dg;
    logic          r_out_vld;

    always_comb begin
        w_s1  = {1'b0, r_dv_s[NUMW]} + 1'b1;
        w_dom = sat_mag(NUMW'(w_s1[SW:1]), 1'b0);
        for (int j = 0; j < 3; j++) begin
            w_off[j] = sat_mag(r_dv_q[NUMW][j], r_dv_neg[NUMW][j]);
        end
        unique case (r_dv_br[NUMW])
            rmq_pkg::BR_TRACE: begin
                n_q[0] = w_dom;    n_q[1] = w_off[0];
                n_q[2] = w_off[1]; n_q[3] = w_off[2];
            end
            rmq_pkg::BR_M00: begin
                n_q[0] = w_off[2]; n_q[1] = w_dom;
                n_q[2] = w_off[0]; n_q[3] = w_off[1];
            end
            rmq_pkg::BR_M11: begin
                n_q[0] = w_off[2]; n_q[1] = w_off[0];
                n_q[2] = w_dom;    n_q[3] = w_off[1];
            end
            default: begin
                n_q[0] = w_off[2]; n_q[1] = w_off[0];
                n_q[2] = w_off[1]; n_q[3] = w_dom;
            end
        endcase
        if (r_dv_dg[NUMW]) begin
            for (int c = 0; c < 4; c++) begin
                n_q[c] = '0;
            end
        end
    end

    // hold the result until the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_dv_vld[NUMW];
        end
        if (w_en) begin
            for (int c = 0; c < 4; c++) begin
                r_q[c] <= n_q[c];
            end
            r_dg <= r_dv_dg[NUMW];
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_dg;
    assign o_m_tdata  = OUT_TW'({r_q[3], r_q[2], r_q[1], r_q[0]});
endmodule
`default_nettype wire

// File: sim/rotation_matrix_to_quaternion_test.sv
// Self-checking testbench for the rotation matrix to quaternion pipeline.
`timescale 1ns / 100ps
`default_nettype none
module rotation_matrix_to_quaternion_test;
    localparam int DW   = 16;
    localparam int FB   = 14;
    localparam int INW  = ((rmq_pkg::N_ELEM*DW+7)/8)*8;
    localparam int OUTW = ((rmq_pkg::N_COMP*DW+7)/8)*8;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic [DW-1:0] qz, qy, qx, qw;
        logic          degen;
    } t_quat;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_s_tvalid = 1'b0;
    logic            o_s_tready;
    logic [INW-1:0]  i_s_tdata = '0;
    logic            o_m_tvalid;
    logic            i_m_tready = 1'b0;
    logic [OUTW-1:0] o_m_tdata;
    logic            o_m_tuser;

    logic [INW-1:0] matrix_queue[$];
    t_quat          quat_queue[$];
    int             error_count = 0;
    int             cycle_count = 0;
    int             send_idle = 0;
    int             recv_idle = 0;

    rotation_matrix_to_quaternion #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Bitwise integer square root, floor
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint clamp_q(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Off-diagonal component: d / (2s), rounded half away from zero
    function automatic logic [DW-1:0] off_comp(longint d, longint unsigned s);
        longint unsigned mag, q;
        mag = (d < 0) ? -d : d;
        q = ((mag << FB) + s) / (2 * s);
        return DW'(clamp_q((d < 0) ? -longint'(q) : longint'(q)));
    endfunction

    function automatic t_quat predict_quat(logic [INW-1:0] data);
        longint m[9];
        longint tr, r;
        longint unsigned s;
        logic [DW-1:0] dom;
        rmq_pkg::t_branch br;
        t_quat q;
        for (int i = 0; i < 9; i++) m[i] = longint'($signed(data[i*DW +: DW]));
        q = '0;
        tr = m[0] + m[4] + m[8];
        if (tr > 0) begin
            br = rmq_pkg::BR_TRACE; r = (1 << FB) + tr;
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            br = rmq_pkg::BR_M00; r = (1 << FB) + m[0] - m[4] - m[8];
        end else if (m[4] > m[8]) begin
            br = rmq_pkg::BR_M11; r = (1 << FB) + m[4] - m[0] - m[8];
        end else begin
            br = rmq_pkg::BR_M22; r = (1 << FB) + m[8] - m[0] - m[4];
        end
        if (r <= 0) begin
            q.degen = 1'b1;
            return q;
        end
        s = int_sqrt(longint'(r) << FB);
        dom = DW'(clamp_q(longint'((s + 1) >> 1)));
        unique case (br)
            rmq_pkg::BR_TRACE: begin
                q.qw = dom;
                q.qx = off_comp(m[7] - m[5], s);
                q.qy = off_comp(m[2] - m[6], s);
                q.qz = off_comp(m[3] - m[1], s);
            end
            rmq_pkg::BR_M00: begin
                q.qx = dom;
                q.qy = off_comp(m[1] + m[3], s);
                q.qz = off_comp(m[6] + m[2], s);
                q.qw = off_comp(m[7] - m[5], s);
            end
            rmq_pkg::BR_M11: begin
                q.qy = dom;
                q.qx = off_comp(m[1] + m[3], s);
                q.qz = off_comp(m[5] + m[7], s);
                q.qw = off_comp(m[2] - m[6], s);
            end
            default: begin
                q.qz = dom;
                q.qx = off_comp(m[2] + m[6], s);
                q.qy = off_comp(m[5] + m[7], s);
                q.qw = off_comp(m[3] - m[1], s);
            end
        endcase
        return q;
    endfunction

    function automatic logic [INW-1:0] pack_matrix(int a0, int a1, int a2, int a3,
            int a4, int a5, int a6, int a7, int a8);
        logic [INW-1:0] v;
        v = '0;
        v[0*DW +: DW] = DW'(a0); v[1*DW +: DW] = DW'(a1); v[2*DW +: DW] = DW'(a2);
        v[3*DW +: DW] = DW'(a3); v[4*DW +: DW] = DW'(a4); v[5*DW +: DW] = DW'(a5);
        v[6*DW +: DW] = DW'(a6); v[7*DW +: DW] = DW'(a7); v[8*DW +: DW] = DW'(a8);
        return v;
    endfunction

    // Random element: mostly near a rotation scale, sometimes full range
    function automatic int rand_elem(bit wide);
        if (wide) return int'($urandom_range(0, 65535));
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    // Driver: present the next request, hold it until accepted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_s_tvalid || o_s_tready) begin
                if (matrix_queue.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= matrix_queue.pop_front();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Predict on each accepted request
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) quat_queue.push_back(predict_quat(i_s_tdata));
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_quat got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tdata[4*DW-1:0], o_m_tuser};
            if (quat_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end else begin
                want = quat_queue.pop_front();
                if (got.qw !== want.qw) begin
                    $display("%0t: qw expected %h actual %h", $time, want.qw, got.qw);
                    error_count++;
                end
                if (got.qx !== want.qx) begin
                    $display("%0t: qx expected %h actual %h", $time, want.qx, got.qx);
                    error_count++;
                end
                if (got.qy !== want.qy) begin
                    $display("%0t: qy expected %h actual %h", $time, want.qy, got.qy);
                    error_count++;
                end
                if (got.qz !== want.qz) begin
                    $display("%0t: qz expected %h actual %h", $time, want.qz, got.qz);
                    error_count++;
                end
                if (got.degen !== want.degen) begin
                    $display("%0t: degenerate expected %b actual %b",
                             $time, want.degen, got.degen);
                    error_count++;
                end
            end
        end
    end

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [INW-1:0] v;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: identity, branches, ties, degenerate, extremes
        matrix_queue.push_back(pack_matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        matrix_queue.push_back(pack_matrix(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        matrix_queue.push_back(pack_matrix(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
        matrix_queue.push_back(pack_matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
        matrix_queue.push_back(pack_matrix(0, -16384, 0, 16384, 0, 0, 0, 0, 0));
        matrix_queue.push_back(pack_matrix(-8192, 1, 2, 3, -8192, 4, 5, 6, -8192));
        matrix_queue.push_back(pack_matrix(-5000, 100, 0, 0, -5000, 0, 0, 0, -9000));
        matrix_queue.push_back(pack_matrix(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
        matrix_queue.push_back(pack_matrix(32767, 32767, 32767, 32768, 32768, 32768,
                                           32767, 32768, 32768));
        matrix_queue.push_back(pack_matrix(32768, 32767, 32768, 32767, 32768, 32767,
                                           32768, 32767, 32768));
        matrix_queue.push_back(pack_matrix(-16384, 32767, 32767, 32767, -16384, 32767,
                                           32767, 32767, 65535));
        matrix_queue.push_back(pack_matrix(-16000, 32768, 32767, 32768, -16000, 32768,
                                           32768, 32767, -16000));
        matrix_queue.push_back(pack_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
        matrix_queue.push_back(pack_matrix(1, 0, 0, 0, 0, 0, 0, 0, 0));
        matrix_queue.push_back(pack_matrix(65535, 65535, 65535, 65535, 65535, 65535,
                                           65535, 65535, 65535));
        matrix_queue.push_back(pack_matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        // Random phases with changing idle ratios
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 33 : (ph == 1) ? 86 : 0;
            recv_idle = (ph == 0) ? 86 : (ph == 1) ? 33 : 0;
            for (int n = 0; n < 430; n++) begin
                bit wide;
                wide = ($urandom_range(0, 3) == 0);
                v = '0;
                for (int e = 0; e < 9; e++) v[e*DW +: DW] = DW'(rand_elem(wide));
                matrix_queue.push_back(v);
            end
            while (matrix_queue.size() > 0 || quat_queue.size() > 0) @(posedge i_clk);
        end
        repeat (60) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire
